FILE: rtl/core/csv_field_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// CSV field tokenizer assertion macros
// Concurrent assertion wrappers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define CSVFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("csvft assertion failed");
// Checked at every edge, reset included.
`define CSVFT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("csvft assertion failed");
`else
`define CSVFT_ASSERT(lbl, prop)
`define CSVFT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/core/csvft_pkg.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Character codes and the structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package csvft_pkg;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] SEP_RESET = 8'd44;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic [7:0] field_index;
    logic       field_end;
    logic       line_end;
  } result_t;

endpackage

FILE: rtl/core/csvft_if.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer channels
// Valid/ready channels for input characters and for tokenizer results.
// ----------------------------------------------------------------------------
interface csvft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface csvft_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic [7:0] field_index;
  logic       field_end;
  logic       line_end;

  modport source (output valid, output has_byte, output out_byte, output field_index,
                  output field_end, output line_end, input ready);
  modport sink (input valid, input has_byte, input out_byte, input field_index,
                input field_end, input line_end, output ready);
endinterface

FILE: rtl/core/csvft_in_reg.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer input register
// Holds one accepted character beat until the parser consumes it.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_defines.svh"

module csvft_in_reg (
  input  logic               clk,
  input  logic               rst,
  csvft_in_if.sink           rx,
  input  logic               take,
  output logic               item_valid,
  output csvft_pkg::item_t   item
);
  import csvft_pkg::*;

  assign rx.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      item.data_byte    <= rx.data_byte;
      item.end_of_input <= rx.end_of_input;
    end
  end

  `CSVFT_ASSERT(a_take_needs_item, take |-> item_valid)
  `CSVFT_ASSERT(a_held_when_stalled, item_valid && !take |=> item_valid && $stable(item))
  `CSVFT_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !item_valid)

endmodule

FILE: rtl/core/csvft_parser.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer parser
// Separator register, parse state and the per-character decision logic.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_defines.svh"

module csvft_parser #(
  parameter int MAX_FIELDS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               separator_we,
  input  logic [7:0]         separator_wdata,
  input  logic               item_valid,
  input  csvft_pkg::item_t   item,
  input  logic               out_free,
  output logic               take,
  output logic               res_valid,
  output csvft_pkg::result_t res
);
  import csvft_pkg::*;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QSEEN
  } mode_t;

  localparam logic [7:0] FieldTop = (MAX_FIELDS - 1 < 255) ? 8'(MAX_FIELDS - 1) : 8'd255;

  logic [7:0] separator;
  mode_t      parse_mode, parse_mode_next;
  logic       cr_pending, cr_pending_next;
  logic [7:0] field_number, field_number_next;
  logic       line_open, line_open_next;
  logic       is_cr, is_lf, is_quote, is_sep;

  assign is_cr    = item.data_byte == CH_CR;
  assign is_lf    = item.data_byte == CH_LF;
  assign is_quote = item.data_byte == CH_QUOTE;
  assign is_sep   = item.data_byte == separator;

  // An item with no result retires even while the output register is full.
  assign take = item_valid && (!res_valid || out_free);

  always_comb begin
    parse_mode_next   = parse_mode;
    cr_pending_next   = cr_pending;
    field_number_next = field_number;
    line_open_next    = line_open;
    res_valid         = 1'b0;
    res               = '0;
    res.field_index   = field_number;
    if (item_valid) begin
      cr_pending_next = 1'b0;
      if (item.end_of_input || ((is_cr || is_lf) && !(is_lf && cr_pending))) begin
        // Line close: reports only when the line saw any character.
        cr_pending_next   = !item.end_of_input && is_cr;
        res_valid         = line_open;
        res.field_end     = 1'b1;
        res.line_end      = 1'b1;
        line_open_next    = 1'b0;
        field_number_next = '0;
        parse_mode_next   = MODE_START;
      end else if (!is_lf) begin
        line_open_next = 1'b1;
        case (parse_mode)
          MODE_START, MODE_PLAIN, MODE_QSEEN: begin
            if (parse_mode == MODE_START && is_quote) begin
              parse_mode_next = MODE_QUOTED;
            end else if (parse_mode == MODE_QSEEN && is_quote) begin
              parse_mode_next = MODE_QUOTED;
              res_valid       = 1'b1;
              res.has_byte    = 1'b1;
              res.out_byte    = CH_QUOTE;
            end else if (is_sep) begin
              res_valid       = 1'b1;
              res.field_end   = 1'b1;
              parse_mode_next = MODE_START;
              if (field_number < FieldTop) begin
                field_number_next = field_number + 8'd1;
              end
            end else begin
              parse_mode_next = MODE_PLAIN;
              res_valid       = 1'b1;
              res.has_byte    = 1'b1;
              res.out_byte    = item.data_byte;
            end
          end
          MODE_QUOTED: begin
            if (is_quote) begin
              parse_mode_next = MODE_QSEEN;
            end else begin
              res_valid    = 1'b1;
              res.has_byte = 1'b1;
              res.out_byte = item.data_byte;
            end
          end
          default: begin
            parse_mode_next = MODE_START;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      separator    <= SEP_RESET;
      parse_mode   <= MODE_START;
      cr_pending   <= 1'b0;
      field_number <= '0;
      line_open    <= 1'b0;
    end else begin
      if (separator_we) begin
        separator <= separator_wdata;
      end
      if (take) begin
        parse_mode   <= parse_mode_next;
        cr_pending   <= cr_pending_next;
        field_number <= field_number_next;
        line_open    <= line_open_next;
      end
    end
  end

  `CSVFT_ASSERT(a_field_saturates, field_number <= FieldTop)
  `CSVFT_ASSERT(a_line_end_ends_field, res_valid && res.line_end |-> res.field_end)
  `CSVFT_ASSERT(a_no_byte_on_field_end, res_valid && res.field_end |-> !res.has_byte)

endmodule

FILE: rtl/core/csvft_out_reg.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer output register
// Registers one result beat and presents it on the output channel.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_defines.svh"

module csvft_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  csvft_pkg::result_t res,
  output logic               out_free,
  csvft_out_if.source        tx
);
  import csvft_pkg::*;

  result_t held;

  assign out_free = !tx.valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (load) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign tx.has_byte    = held.has_byte;
  assign tx.out_byte    = held.out_byte;
  assign tx.field_index = held.field_index;
  assign tx.field_end   = held.field_end;
  assign tx.line_end    = held.line_end;

  `CSVFT_ASSERT(a_load_only_when_free, load |-> out_free)
  `CSVFT_ASSERT(a_shown_after_load, load |=> tx.valid)
  `CSVFT_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !tx.valid)

endmodule

FILE: rtl/core/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Splits a character stream into fields (comma-separated by default) and lines.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one character beat (data_byte, end_of_input); tx carries at most
//   one result beat per character: a content byte, a field end, or a field and
//   line end together. Opening quotes, quote pairs in progress, the LF of a
//   CR-LF pair and line breaks on an empty line produce no result beat.
//   separator_we/separator_wdata write the separator; write it only while idle.
//   A result beat reaches tx through the input register, then the parse logic
//   into the output register. Throughput: one character per cycle while tx
//   accepts results; the parse state update is a single registered step, so
//   back-to-back beats flow without bubbles.
//   When tx stalls, the input register holds one more character and rx.ready
//   drops only if that character would produce a result; beats with no result
//   keep draining. Reset empties both registers, restores the comma separator
//   and returns the parser to the start of a line at field zero.
// ----------------------------------------------------------------------------
module csv_field_tokenizer #(
  parameter int MAX_FIELDS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        separator_we,
  input  logic [7:0]  separator_wdata,
  csvft_in_if.sink    rx,
  csvft_out_if.source tx
);
  import csvft_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    take;
  logic    out_free;
  logic    res_valid;
  result_t res;

  csvft_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  csvft_parser #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .separator_we    (separator_we),
    .separator_wdata (separator_wdata),
    .item_valid      (item_valid),
    .item            (item),
    .out_free        (out_free),
    .take            (take),
    .res_valid       (res_valid),
    .res             (res)
  );

  csvft_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (take && res_valid),
    .res      (res),
    .out_free (out_free),
    .tx       (tx)
  );

endmodule
